@@ rtl/core/pf2rgb_pkg.sv @@
package pf2rgb_pkg;

   // Source format codes held in the pixel_format register
   localparam logic [2:0] FMT_RGB10A2    = 3'd0;
   localparam logic [2:0] FMT_RGBA8      = 3'd1;
   localparam logic [2:0] FMT_BGRA8      = 3'd2;
   localparam logic [2:0] FMT_RGBA16F    = 3'd3;
   localparam logic [2:0] FMT_R11G11B10F = 3'd4;
   localparam logic [2:0] FMT_RESET      = FMT_RGBA8;

   // Register index of pixel_format (address bit 2 selects the register)
   localparam logic REG_PIXEL_FORMAT = 1'b0;

   // Small float constants: 5-bit exponent, bias 15
   localparam logic [4:0] EXP_MAX         = 5'd31;
   localparam logic [4:0] EXP_BIAS        = 5'd15;
   localparam logic [4:0] DENORM_SHIFT    = 5'd14;
   localparam logic [3:0] HALF_MANT_BITS  = 4'd10;
   localparam logic [3:0] RG11_MANT_BITS  = 4'd6;
   localparam logic [3:0] B10_MANT_BITS   = 4'd5;
   localparam logic [9:0] MANT_SCALE      = 10'd510;

   // One channel after unpacking: either a finished byte or a fraction to scale
   typedef struct packed {
      logic        scale;
      logic [10:0] mant;
      logic [4:0]  shift;
      logic [7:0]  byte_val;
   } chan_dec_type;

   // Unpacked pixel transaction
   typedef struct packed {
      chan_dec_type red;
      chan_dec_type green;
      chan_dec_type blue;
      logic         supported;
      logic         row_end;
   } dec_type;

   // Finished byte channel
   function automatic chan_dec_type byte_chan(logic [7:0] v);
      chan_dec_type c;
      c.scale    = 1'b0;
      c.mant     = '0;
      c.shift    = '0;
      c.byte_val = v;
      return c;
   endfunction

   // Unsigned small float: value = mant_int / 2^shift, or a saturated or zero byte
   function automatic chan_dec_type small_float(logic [9:0] mant, logic [4:0] expo,
                                                logic [3:0] mbits);
      chan_dec_type c;
      c = byte_chan(8'd0);
      if (expo == EXP_MAX) begin
         // infinity saturates, NaN goes to zero
         c.byte_val = (mant != 10'd0) ? 8'd0 : 8'd255;
      end else if (expo >= EXP_BIAS) begin
         c.byte_val = 8'd255;
      end else begin
         c.scale = 1'b1;
         if (expo == 5'd0) begin
            c.mant  = {1'b0, mant};
            c.shift = DENORM_SHIFT + {1'b0, mbits};
         end else begin
            c.mant  = (11'd1 << mbits) | {1'b0, mant};
            c.shift = (EXP_BIAS - expo) + {1'b0, mbits};
         end
      end
      return c;
   endfunction

   // Half float: any value with the sign set gives zero
   function automatic chan_dec_type half_chan(logic [15:0] h);
      chan_dec_type c;
      if (h[15]) begin
         c = byte_chan(8'd0);
      end else begin
         c = small_float(h[9:0], h[14:10], HALF_MANT_BITS);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/pf2rgb_csr.sv @@
module pf2rgb_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [2:0]  pixel_format
);

   logic [2:0] pixel_format_ff;
   logic [2:0] pixel_format_in;
   logic       wr_hit;

   // Decode a completed write to the format register
   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == pf2rgb_pkg::REG_PIXEL_FORMAT);

   always_comb begin
      pixel_format_in = pixel_format_ff;
      if (wr_hit) begin
         pixel_format_in = csr_pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= pf2rgb_pkg::FMT_RESET;
      end else begin
         pixel_format_ff <= pixel_format_in;
      end
   end

   // Read back the register, zero elsewhere
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == pf2rgb_pkg::REG_PIXEL_FORMAT) begin
         csr_prdata = {29'd0, pixel_format_ff};
      end
   end

   assign csr_pready   = 1'b1;
   assign pixel_format = pixel_format_ff;

endmodule

@@ rtl/core/pf2rgb_decode.sv @@
module pf2rgb_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          pixel_format,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [63:0]         pixel_word,
   input  logic                row_end,
   output logic                dec_valid,
   input  logic                dec_ready,
   output pf2rgb_pkg::dec_type dec
);

   logic                dec_valid_ff;
   logic                dec_valid_in;
   pf2rgb_pkg::dec_type dec_ff;
   pf2rgb_pkg::dec_type dec_in;
   logic                advance;

   // Stage moves when empty or when the next stage takes its transaction
   assign advance  = !dec_valid_ff || dec_ready;
   assign in_ready = advance;

   // Unpack channels per source format
   always_comb begin
      dec_in.red       = pf2rgb_pkg::byte_chan(8'd0);
      dec_in.green     = pf2rgb_pkg::byte_chan(8'd0);
      dec_in.blue      = pf2rgb_pkg::byte_chan(8'd0);
      dec_in.supported = 1'b1;
      dec_in.row_end   = row_end;
      case (pixel_format)
         pf2rgb_pkg::FMT_RGB10A2: begin
            dec_in.red   = pf2rgb_pkg::byte_chan(pixel_word[9:2]);
            dec_in.green = pf2rgb_pkg::byte_chan(pixel_word[19:12]);
            dec_in.blue  = pf2rgb_pkg::byte_chan(pixel_word[29:22]);
         end
         pf2rgb_pkg::FMT_RGBA8: begin
            dec_in.red   = pf2rgb_pkg::byte_chan(pixel_word[7:0]);
            dec_in.green = pf2rgb_pkg::byte_chan(pixel_word[15:8]);
            dec_in.blue  = pf2rgb_pkg::byte_chan(pixel_word[23:16]);
         end
         pf2rgb_pkg::FMT_BGRA8: begin
            dec_in.blue  = pf2rgb_pkg::byte_chan(pixel_word[7:0]);
            dec_in.green = pf2rgb_pkg::byte_chan(pixel_word[15:8]);
            dec_in.red   = pf2rgb_pkg::byte_chan(pixel_word[23:16]);
         end
         pf2rgb_pkg::FMT_RGBA16F: begin
            dec_in.red   = pf2rgb_pkg::half_chan(pixel_word[15:0]);
            dec_in.green = pf2rgb_pkg::half_chan(pixel_word[31:16]);
            dec_in.blue  = pf2rgb_pkg::half_chan(pixel_word[47:32]);
         end
         pf2rgb_pkg::FMT_R11G11B10F: begin
            dec_in.red   = pf2rgb_pkg::small_float({4'd0, pixel_word[5:0]},
                              pixel_word[10:6], pf2rgb_pkg::RG11_MANT_BITS);
            dec_in.green = pf2rgb_pkg::small_float({4'd0, pixel_word[16:11]},
                              pixel_word[21:17], pf2rgb_pkg::RG11_MANT_BITS);
            dec_in.blue  = pf2rgb_pkg::small_float({5'd0, pixel_word[26:22]},
                              pixel_word[31:27], pf2rgb_pkg::B10_MANT_BITS);
         end
         default: begin
            dec_in.supported = 1'b0;
         end
      endcase
   end

   assign dec_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (advance) begin
         dec_valid_ff <= dec_valid_in;
      end
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff <= dec_in;
      end
   end

   assign dec_valid = dec_valid_ff;
   assign dec       = dec_ff;

endmodule

@@ rtl/core/pf2rgb_scale.sv @@
module pf2rgb_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                dec_valid,
   output logic                dec_ready,
   input  pf2rgb_pkg::dec_type dec,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic                rsp_supported,
   output logic                rsp_row_end_out
);

   typedef struct packed {
      logic        scale;
      logic [19:0] prod;
      logic [4:0]  shift;
      logic [7:0]  byte_val;
   } chan_prod_type;

   typedef struct packed {
      chan_prod_type red;
      chan_prod_type green;
      chan_prod_type blue;
      logic          supported;
      logic          row_end;
   } prod_type;

   logic       prod_valid_ff;
   prod_type   prod_ff;
   prod_type   prod_in;
   logic       prod_advance;
   logic       out_advance;
   logic       rsp_valid_ff;
   logic [7:0] rsp_red_ff;
   logic [7:0] rsp_green_ff;
   logic [7:0] rsp_blue_ff;
   logic       rsp_supported_ff;
   logic       rsp_row_end_ff;
   logic [7:0] rsp_red_in;
   logic [7:0] rsp_green_in;
   logic [7:0] rsp_blue_in;

   // Multiply the fraction by 2*255
   function automatic chan_prod_type mul_chan(pf2rgb_pkg::chan_dec_type c);
      chan_prod_type p;
      p.scale    = c.scale;
      p.prod     = 20'({9'd0, c.mant}) * 20'(pf2rgb_pkg::MANT_SCALE);
      p.shift    = c.shift;
      p.byte_val = c.byte_val;
      return p;
   endfunction

   // Add one half and drop the fraction bits: round half up
   function automatic logic [7:0] round_chan(chan_prod_type p);
      logic [25:0] sum;
      logic [7:0]  res;
      sum = {6'd0, p.prod} + (26'd1 << p.shift);
      res = 8'(sum >> (p.shift + 5'd1));
      return p.scale ? res : p.byte_val;
   endfunction

   assign out_advance  = !rsp_valid_ff || !rsp_stall;
   assign prod_advance = !prod_valid_ff || out_advance;
   assign dec_ready    = prod_advance;

   // Multiply stage
   always_comb begin
      prod_in.red       = mul_chan(dec.red);
      prod_in.green     = mul_chan(dec.green);
      prod_in.blue      = mul_chan(dec.blue);
      prod_in.supported = dec.supported;
      prod_in.row_end   = dec.row_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_advance) begin
         prod_valid_ff <= dec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_advance) begin
         prod_ff <= prod_in;
      end
   end

   // Round and shift into the output register
   always_comb begin
      rsp_red_in   = round_chan(prod_ff.red);
      rsp_green_in = round_chan(prod_ff.green);
      rsp_blue_in  = round_chan(prod_ff.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance) begin
         rsp_red_ff       <= rsp_red_in;
         rsp_green_ff     <= rsp_green_in;
         rsp_blue_ff      <= rsp_blue_in;
         rsp_supported_ff <= prod_ff.supported;
         rsp_row_end_ff   <= prod_ff.row_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_supported   = rsp_supported_ff;
   assign rsp_row_end_out = rsp_row_end_ff;

endmodule

@@ rtl/core/pixel_format_to_rgb888.sv @@
// Converts one packed pixel word per transaction to 8-bit red, green and blue under the
// format held in pixel_format (0 rgb10a2, 1 rgba8, 2 bgra8, 3 rgba16 half, 4 r11g11b10
// float; other codes give zero channels with rsp_supported low). Float channels are
// decoded exactly, clamped to [0,1] and rounded as round(v*255), ties up; negatives and
// NaN give 0, infinity and values of 1.0 or more give 255. The block takes one pixel
// every cycle unless the output stalls; pixels pass the unpack and multiply registers,
// are rounded into the output register, and a stalled output lets the pipeline fill
// before req_stall rises. Write pixel_format only while no pixel is in flight.
module pixel_format_to_rgb888 (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_pixel_word,
   input  logic        req_row_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_supported,
   output logic        rsp_row_end_out
);

   logic [2:0]          pixel_format;
   logic                in_ready;
   logic                dec_valid;
   logic                dec_ready;
   pf2rgb_pkg::dec_type dec;

   pf2rgb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .pixel_format (pixel_format)
   );

   pf2rgb_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .pixel_format (pixel_format),
      .in_valid     (req_valid),
      .in_ready     (in_ready),
      .pixel_word   (req_pixel_word),
      .row_end      (req_row_end),
      .dec_valid    (dec_valid),
      .dec_ready    (dec_ready),
      .dec          (dec)
   );

   pf2rgb_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .dec_valid       (dec_valid),
      .dec_ready       (dec_ready),
      .dec             (dec),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_supported   (rsp_supported),
      .rsp_row_end_out (rsp_row_end_out)
   );

   assign req_stall = !in_ready;

   // Unsupported formats never carry channel data
   a_unsupported_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_supported) |-> (rsp_red == 8'd0 && rsp_green == 8'd0 &&
                                         rsp_blue == 8'd0))
      else $error("unsupported pixel with nonzero channel");

   // An accepted transaction lands in the unpack stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> dec_valid)
      else $error("accepted transaction lost at unpack stage");

   // A register write takes effect on the next cycle
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       csr_paddr[2] == pf2rgb_pkg::REG_PIXEL_FORMAT)
      |=> (pixel_format == $past(csr_pwdata[2:0])))
      else $error("pixel_format write not applied");

   // Input never stalls while the unpack stage is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !dec_valid |-> !req_stall)
      else $error("stall with empty unpack stage");

endmodule

@@ sim/pf2rgb_checker.sv @@
module pf2rgb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_pixel_word,
   input  logic        req_row_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic        rsp_supported,
   input  logic        rsp_row_end_out,
   output int          fail_count,
   output int          pixels_in_flight
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       supported;
      logic       row_end;
   } rgb_pixel_type;

   rgb_pixel_type expected_pixels[$];
   rgb_pixel_type want_pixel;
   logic [2:0]    format_q;
   int            mismatch_total = 0;

   // Unsigned 5-bit-exponent float to a byte: clamp to [0,1], round(v*255) ties up
   function automatic logic [7:0] float_to_byte(logic [9:0] mant, logic [4:0] expo, int mbits);
      logic [63:0] frac;
      int          sh;
      if (expo == pf2rgb_pkg::EXP_MAX) return (mant != 10'd0) ? 8'd0 : 8'd255;
      if (expo >= pf2rgb_pkg::EXP_BIAS) return 8'd255;
      if (expo == 5'd0) begin
         frac = {54'd0, mant};
         sh   = 14 + mbits;
      end else begin
         frac = (64'd1 << mbits) | {54'd0, mant};
         sh   = 15 - int'(expo) + mbits;
      end
      if (frac == 64'd0) return 8'd0;
      frac = (frac * 64'd510 + (64'd1 << sh)) >> (sh + 1);
      return frac[7:0];
   endfunction

   // Half float: anything with the sign bit set goes to zero
   function automatic logic [7:0] half_to_byte(logic [15:0] h);
      if (h[15]) return 8'd0;
      return float_to_byte(h[9:0], h[14:10], 10);
   endfunction

   // Predict the output transaction for one pixel under the given format
   function automatic rgb_pixel_type convert_pixel(logic [2:0] fmt, logic [63:0] w, logic re);
      rgb_pixel_type p;
      p = '0;
      p.supported = 1'b1;
      p.row_end   = re;
      case (fmt)
         pf2rgb_pkg::FMT_RGB10A2: begin
            p.red   = w[9:2];
            p.green = w[19:12];
            p.blue  = w[29:22];
         end
         pf2rgb_pkg::FMT_RGBA8: begin
            p.red   = w[7:0];
            p.green = w[15:8];
            p.blue  = w[23:16];
         end
         pf2rgb_pkg::FMT_BGRA8: begin
            p.blue  = w[7:0];
            p.green = w[15:8];
            p.red   = w[23:16];
         end
         pf2rgb_pkg::FMT_RGBA16F: begin
            p.red   = half_to_byte(w[15:0]);
            p.green = half_to_byte(w[31:16]);
            p.blue  = half_to_byte(w[47:32]);
         end
         pf2rgb_pkg::FMT_R11G11B10F: begin
            p.red   = float_to_byte({4'd0, w[5:0]}, w[10:6], 6);
            p.green = float_to_byte({4'd0, w[16:11]}, w[21:17], 6);
            p.blue  = float_to_byte({5'd0, w[26:22]}, w[31:27], 5);
         end
         default: begin
            p.supported = 1'b0;
         end
      endcase
      return p;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatch_total++;
      end
   endtask

   // Track the format register, queue predictions, compare results in order
   always @(posedge clock) begin
      if (reset) begin
         format_q = pf2rgb_pkg::FMT_RESET;
         expected_pixels.delete();
      end else begin
         // follow register writes, check reads of the format register
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == pf2rgb_pkg::REG_PIXEL_FORMAT) format_q = csr_pwdata[2:0];
            end else if (csr_paddr[2] == pf2rgb_pkg::REG_PIXEL_FORMAT &&
                         csr_prdata !== {29'd0, format_q}) begin
               $display("%0t: pixel_format read mismatch: expected %0d, actual %0d",
                        $time, format_q, csr_prdata);
               mismatch_total++;
            end
         end

         // append the prediction for an accepted pixel
         if (req_valid && !req_stall)
            expected_pixels = {expected_pixels,
                               convert_pixel(format_q, req_pixel_word, req_row_end)};

         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected transaction: expected none, actual %0d/%0d/%0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               mismatch_total++;
            end else begin
               want_pixel = expected_pixels.pop_front();
               check_field("red", want_pixel.red, rsp_red);
               check_field("green", want_pixel.green, rsp_green);
               check_field("blue", want_pixel.blue, rsp_blue);
               check_field("supported", {7'd0, want_pixel.supported}, {7'd0, rsp_supported});
               check_field("row_end_out", {7'd0, want_pixel.row_end}, {7'd0, rsp_row_end_out});
            end
         end
      end
      fail_count       <= mismatch_total;
      pixels_in_flight <= expected_pixels.size();
   end

endmodule

@@ sim/tb_top.sv @@
module tb_top;

   localparam logic [2:0] ADDR_PIXEL_FORMAT = {pf2rgb_pkg::REG_PIXEL_FORMAT, 2'b00};
   localparam logic [2:0] ADDR_UNUSED       = {~pf2rgb_pkg::REG_PIXEL_FORMAT, 2'b00};
   localparam logic [2:0] FMT_RSVD5         = 3'd5;
   localparam logic [2:0] FMT_RSVD6         = 3'd6;
   localparam logic [2:0] FMT_RSVD7         = 3'd7;
   localparam int         NUM_PHASES        = 12;
   localparam int         PHASE_ITEMS       = 110;
   localparam int         LONG_HOLD_CYCLES  = 80;
   localparam int         DRAIN_CYCLES      = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_pixel_word = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_supported;
   logic        rsp_row_end_out;

   int          checker_failures;
   int          pixels_in_flight;
   logic        send_gappy = 1'b1;
   logic        recv_gappy = 1'b1;
   logic        hold_request = 1'b0;

   logic [2:0]  phase_formats [NUM_PHASES] = '{
      pf2rgb_pkg::FMT_RGBA8, pf2rgb_pkg::FMT_RGB10A2, pf2rgb_pkg::FMT_BGRA8,
      pf2rgb_pkg::FMT_RGBA16F, pf2rgb_pkg::FMT_R11G11B10F, FMT_RSVD5,
      pf2rgb_pkg::FMT_RGBA16F, pf2rgb_pkg::FMT_R11G11B10F, FMT_RSVD7,
      pf2rgb_pkg::FMT_RGB10A2, FMT_RSVD6, pf2rgb_pkg::FMT_RGBA16F};

   pixel_format_to_rgb888 dut (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid), .req_stall(req_stall), .req_pixel_word(req_pixel_word),
      .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_red(rsp_red),
      .rsp_green(rsp_green), .rsp_blue(rsp_blue), .rsp_supported(rsp_supported),
      .rsp_row_end_out(rsp_row_end_out)
   );

   pf2rgb_checker pixel_checker (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid), .req_stall(req_stall), .req_pixel_word(req_pixel_word),
      .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_red(rsp_red),
      .rsp_green(rsp_green), .rsp_blue(rsp_blue), .rsp_supported(rsp_supported),
      .rsp_row_end_out(rsp_row_end_out),
      .fail_count(checker_failures), .pixels_in_flight(pixels_in_flight)
   );

   always #10 clock = ~clock;

   // Bound the run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Drain results, with random stalls and an occasional long hold-off
   initial begin
      int n;
      forever begin
         if (hold_request) begin
            n = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            n = recv_gappy ? $urandom_range(0, 9) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Exponent spread: mostly the scaled range, some denormal, saturating and inf/NaN
   function automatic logic [4:0] rand_exponent();
      case ($urandom_range(0, 9))
         0:       return 5'd0;
         1:       return pf2rgb_pkg::EXP_MAX;
         2:       return 5'($urandom_range(15, 30));
         default: return 5'($urandom_range(1, 14));
      endcase
   endfunction

   function automatic logic [9:0] rand_mant();
      return ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom);
   endfunction

   function automatic logic [15:0] rand_half();
      logic [9:0] m;
      m = rand_mant();
      return {($urandom_range(0, 3) == 0), rand_exponent(), m};
   endfunction

   // Random pixel, shaped toward meaningful float encodings for the float formats
   function automatic logic [63:0] rand_pixel(logic [2:0] fmt);
      logic [63:0] w;
      logic [9:0]  mr, mg, mb;
      w  = {$urandom, $urandom};
      mr = rand_mant();
      mg = rand_mant();
      mb = rand_mant();
      if ($urandom_range(0, 4) != 0) begin
         if (fmt == pf2rgb_pkg::FMT_RGBA16F)
            w[47:0] = {rand_half(), rand_half(), rand_half()};
         else if (fmt == pf2rgb_pkg::FMT_R11G11B10F)
            w[31:0] = {rand_exponent(), mb[4:0], rand_exponent(), mg[5:0],
                       rand_exponent(), mr[5:0]};
      end
      return w;
   endfunction

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] addr);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one pixel after a random gap and hold it until accepted
   task automatic send_pixel(input logic [63:0] word, input logic re);
      int gap;
      gap = send_gappy ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_word <= word;
      req_row_end    <= re;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait for every predicted result plus pipeline slack
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_in_flight != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      logic [2:0]  fmt;
      logic [63:0] directed_words[$];
      logic [7:0]  seen_formats;
      seen_formats = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read(ADDR_PIXEL_FORMAT);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         fmt        = phase_formats[phase];
         send_gappy = (phase % 4 != 1);
         recv_gappy = (phase % 4 != 2);

         // first phase runs on the reset format
         if (phase > 0) csr_write(ADDR_PIXEL_FORMAT, {29'($urandom), fmt});
         // a write to an unused index must leave the format alone
         if (phase == 6) csr_write(ADDR_UNUSED, $urandom);
         csr_read(ADDR_PIXEL_FORMAT);

         // edge cases, once per format
         directed_words.delete();
         if (!seen_formats[fmt]) begin
            case (fmt)
               pf2rgb_pkg::FMT_RGB10A2: directed_words = '{64'd0, '1};
               pf2rgb_pkg::FMT_RGBA8:   directed_words = '{'1, 64'hA5A5A5A5_00123456};
               pf2rgb_pkg::FMT_BGRA8:   directed_words = '{64'h5A5A5A5A_FF123456};
               pf2rgb_pkg::FMT_RGBA16F: directed_words = '{
                  {16'h0000, 16'h0001, 16'h8000, 16'h0000},   // zero, denormal, minus zero
                  {16'h0000, 16'h3c00, 16'h3bff, 16'h03ff},   // one, just below one
                  {16'hffff, 16'hfc00, 16'h7e00, 16'h7c00},   // inf, NaN, minus inf
                  {16'hffff, 16'h7bff, 16'h0400, 16'h3800}};  // half tie, min normal, max
               pf2rgb_pkg::FMT_R11G11B10F: directed_words = '{
                  {32'd0, 5'd0, 5'd1, pf2rgb_pkg::EXP_MAX, 6'd1, pf2rgb_pkg::EXP_MAX, 6'd0},
                  {32'd0, 5'd14, 5'd31, pf2rgb_pkg::EXP_BIAS, 6'd0, 5'd0, 6'd0},
                  {32'hffffffff, pf2rgb_pkg::EXP_MAX, 5'd31, 5'd0, 6'd63, 5'd14, 6'd63}};
               default:       directed_words = '{'1};
            endcase
            seen_formats[fmt] = 1'b1;
         end
         foreach (directed_words[i]) send_pixel(directed_words[i], i[0]);

         // back-pressure: hold the output while the input runs flat out
         if (phase == 3) begin
            send_gappy   = 1'b0;
            hold_request = 1'b1;
         end

         repeat (PHASE_ITEMS) send_pixel(rand_pixel(fmt), ($urandom_range(0, 7) == 0));
         wait_drained();
      end

      if (checker_failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/pf2rgb_pkg.sv
rtl/core/pf2rgb_csr.sv
rtl/core/pf2rgb_decode.sv
rtl/core/pf2rgb_scale.sv
rtl/core/pixel_format_to_rgb888.sv
sim/pf2rgb_checker.sv
sim/tb_top.sv
